>>> sv/two_opt_tour_improver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2-opt tour improver
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_OPT_TOUR_IMPROVER_ASSERT_SVH
`define TWO_OPT_TOUR_IMPROVER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define TOI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("check failed");
// condition must never be true outside reset
`define TOI_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TOI_ASSERT(lbl, clk, rstn, !(cond))
`else
`define TOI_ASSERT(lbl, clk, rstn, prop)
`define TOI_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> sv/toi_pkg.sv
// ----------------------------------------------------------------------------
// toi_pkg
// Shared types, register map and helpers of the 2-opt tour improver.
// ----------------------------------------------------------------------------
package toi_pkg;

  // default sizing
  localparam int unsigned MAX_POINTS_DEF     = 64;
  localparam int unsigned COORD_BITS_DEF     = 16;
  localparam int unsigned DIST_FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CRD_W   = 16;
  localparam int unsigned PCNT_W  = 7;
  localparam int unsigned TCNT_W  = 24;
  localparam int unsigned RNG_W   = 32;
  localparam int unsigned PADDR_W = 4;

  localparam logic [RNG_W-1:0] RNG_RESET = 32'd2463534242;

  // register map (word index)
  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_TRIAL_COUNT = 2'd1;
  localparam logic [1:0] REG_RNG_SEED    = 2'd2;

  // item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_B_RDI, ST_B_GETI, ST_B_RDJ, ST_B_DIFF,
    ST_B_SQX, ST_B_SQY, ST_B_SQS, ST_B_ROOT, ST_B_WR,
    ST_T_CHK, ST_T_MODA, ST_T_RNGB, ST_T_MODB, ST_T_ORD,
    ST_T_RTA, ST_T_RTB, ST_T_RTC, ST_T_RTD,
    ST_T_D1, ST_T_D2, ST_T_D3, ST_T_D4, ST_T_ADD, ST_T_CMP,
    ST_T_REVS, ST_SW0, ST_SW1, ST_SW2, ST_SW3,
    ST_E_RD, ST_E_LD, ST_E_OUT
  } state_e;

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] v;
    v = s;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage

>>> sv/two_opt_tour_improver.sv
// ----------------------------------------------------------------------------
// two_opt_tour_improver
// Random 2-opt local search over a closed tour held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage: the slave stream takes words; tuser selects a load (0) or a run (1).
// A load word writes one point and one initial tour entry, so loads stream at
// one word per cycle while idle. A run word builds the distance table (upper
// triangle, one entry per pair), then performs trial_count random 2-opt trials,
// then emits n words on the master stream, tlast on the final one. The table
// build is paced by the one-bit-per-cycle square root unit and each trial by two
// 32-step serial modulo passes; a trial whose two draws match is skipped, and an
// applied trial swaps tour entry pairs one pair at a time. The emitted words are
// handed over only when the sink is ready.
// The slave side is not ready while a run is in progress. A stalled sink just
// holds the current output word; the block waits and loses nothing.
// Reset sets the state machine, config registers and generator to reset values;
// point, tour and distance memories are undefined until written. Configuration is
// to be written through the APB port while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`include "two_opt_tour_improver_assert.svh"

module two_opt_tour_improver #(
  parameter int unsigned MAX_POINTS     = toi_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS     = toi_pkg::COORD_BITS_DEF,
  parameter int unsigned DIST_FRAC_BITS = toi_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: point_index[5:0], x_coord[21:6], y_coord[37:22], tour_city[43:38]
  input  logic [47:0] s_axis_tdata,
  // tuser: mode[0]
  input  logic        s_axis_tuser,
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: tour_position[5:0], city_at_position[11:6]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [toi_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned MW  = CW + 1;
  localparam int unsigned PW  = IW + 1;
  localparam int unsigned XW  = (COORD_BITS < toi_pkg::CRD_W) ? COORD_BITS : toi_pkg::CRD_W;
  localparam int unsigned SW  = 2 * XW + 1;
  localparam int unsigned K   = COORD_BITS + DIST_FRAC_BITS + 1;
  localparam int unsigned RW  = 2 * K;
  localparam int unsigned KCW = $clog2(K + 1);
  localparam int unsigned DW  = K;
  localparam int unsigned DEPTH  = 1 << (2 * IW);
  localparam int unsigned IDX_W  = toi_pkg::IDX_W;
  localparam logic [toi_pkg::PCNT_W-1:0] MAXP = toi_pkg::PCNT_W'(MAX_POINTS);

  // memories
  logic [2*XW-1:0]  coord_mem [MAX_POINTS];
  logic [IDX_W-1:0] tour_mem  [MAX_POINTS];
  logic [DW-1:0]    dist_mem  [DEPTH];

  // config registers
  logic [toi_pkg::PCNT_W-1:0] point_count_q;
  logic [toi_pkg::TCNT_W-1:0] trial_count_q;
  logic [toi_pkg::RNG_W-1:0]  rng_seed_q;

  toi_pkg::state_e state_q, state_d;
  logic [toi_pkg::RNG_W-1:0] rng_q, rng_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_pos_q, out_pos_d, out_city_q, out_city_d;
  logic             out_last_q, out_last_d;

  logic [CW-1:0]    n_q, n_d, i_q, i_d, j_q, j_d;
  logic [XW-1:0]    xi_q, xi_d, yi_q, yi_d, dx_q, dx_d, dy_q, dy_d;
  logic [XW-1:0]    mul_in;
  logic [2*XW-1:0]  mul_q, acc_q, acc_d;
  logic [RW-1:0]    rad_q, rad_d;
  logic [K+2:0]     sqr_q, sqr_d;
  logic [K-1:0]     root_q, root_d;
  logic [KCW-1:0]   k_q, k_d;
  logic [toi_pkg::TCNT_W-1:0] tcnt_q, tcnt_d;
  logic [toi_pkg::RNG_W-1:0]  mod_val_q, mod_val_d;
  logic [MW-1:0]    mod_rem_q, mod_rem_d;
  logic [4:0]       mod_cnt_q, mod_cnt_d;
  logic [IW-1:0]    a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [IW-1:0]    ca_q, ca_d, cb_q, cb_d, cc_q, cc_d, cd_q, cd_d;
  logic [DW:0]      new_q, new_d, old_q, old_d;
  logic [PW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0] tp_q, tp_d;

  // memory ports
  logic                 coord_we, coord_re;
  logic [IW-1:0]        coord_waddr, coord_raddr;
  logic [2*XW-1:0]      coord_wdata, coord_rd_q;
  logic                 tour_we, tour_re;
  logic [IW-1:0]        tour_waddr, tour_raddr;
  logic [IDX_W-1:0]     tour_wdata, tour_rd_q;
  logic                 dist_we, dist_re;
  logic [2*IW-1:0]      dist_waddr, dist_raddr;
  logic                 diag_d, diag_q;
  logic [DW-1:0]        dist_rd_q, dv;

  // input fields
  logic             in_acc;
  logic             in_mode;
  logic [IDX_W-1:0] in_idx, in_city;
  logic [15:0]      in_x, in_y;

  assign in_mode = s_axis_tuser;
  assign in_idx  = s_axis_tdata[5:0];
  assign in_x    = s_axis_tdata[21:6];
  assign in_y    = s_axis_tdata[37:22];
  assign in_city = s_axis_tdata[43:38];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == toi_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_city_q, out_pos_q};
  assign m_axis_tlast  = out_last_q;

  // APB register file
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      toi_pkg::REG_POINT_COUNT: prdata = 32'(point_count_q);
      toi_pkg::REG_TRIAL_COUNT: prdata = 32'(trial_count_q);
      toi_pkg::REG_RNG_SEED:    prdata = rng_seed_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= MAXP;
      trial_count_q <= '0;
      rng_seed_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        toi_pkg::REG_POINT_COUNT: point_count_q <= pwdata[toi_pkg::PCNT_W-1:0];
        toi_pkg::REG_TRIAL_COUNT: trial_count_q <= pwdata[toi_pkg::TCNT_W-1:0];
        toi_pkg::REG_RNG_SEED:    rng_seed_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // helpers
  function automatic logic [IW-1:0] sat_city(input logic [IDX_W-1:0] c,
                                             input logic [CW-1:0] n);
    logic [IDX_W:0] cx, nx;
    cx = (IDX_W+1)'(c);
    nx = (IDX_W+1)'(n);
    if (cx >= nx) return IW'(nx - 1'b1);
    return IW'(c);
  endfunction

  function automatic logic [IW-1:0] wrap_pos(input logic [PW-1:0] p,
                                             input logic [CW-1:0] n);
    if (p < PW'(n)) return IW'(p);
    return IW'(p - PW'(n));
  endfunction

  // shared serial modulo step: one dividend bit per cycle
  logic [MW-1:0] mod_step;
  always_comb begin
    mod_step = {mod_rem_q[MW-2:0], mod_val_q[toi_pkg::RNG_W-1]};
    if (mod_step >= MW'(n_q)) mod_step = mod_step - MW'(n_q);
  end

  // square root digit step
  logic [K+2:0] sq_rm, sq_trial;
  always_comb begin
    sq_rm    = {sqr_q[K:0], rad_q[RW-1:RW-2]};
    sq_trial = (K+3)'({root_q, 2'b01});
  end

  assign dv = diag_q ? '0 : dist_rd_q;

  // sequencer
  always_comb begin
    logic [CW-1:0]    bv, mn, mx;
    logic [XW-1:0]    xj, yj;
    logic [PW-1:0]    bc, ad;
    logic [toi_pkg::PCNT_W-1:0] pc;
    logic [IW-1:0]    px, py;
    state_d     = state_q;
    rng_d       = rng_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_city_d  = out_city_q;
    out_last_d  = out_last_q;
    n_d = n_q; i_d = i_q; j_d = j_q;
    xi_d = xi_q; yi_d = yi_q; dx_d = dx_q; dy_d = dy_q;
    acc_d = acc_q; rad_d = rad_q; sqr_d = sqr_q; root_d = root_q; k_d = k_q;
    tcnt_d = tcnt_q; mod_val_d = mod_val_q; mod_rem_d = mod_rem_q;
    mod_cnt_d = mod_cnt_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    ca_d = ca_q; cb_d = cb_q; cc_d = cc_q; cd_d = cd_q;
    new_d = new_q; old_d = old_q; lo_d = lo_q; hi_d = hi_q; tp_d = tp_q;
    mul_in = '0;
    coord_we = 1'b0; coord_waddr = IW'(in_idx);
    coord_wdata = {in_y[XW-1:0], in_x[XW-1:0]};
    coord_re = 1'b0; coord_raddr = '0;
    tour_we = 1'b0; tour_waddr = IW'(in_idx); tour_wdata = in_city;
    tour_re = 1'b0; tour_raddr = '0;
    dist_we = 1'b0; dist_waddr = {i_q[IW-1:0], j_q[IW-1:0]};
    dist_re = 1'b0; dist_raddr = '0; diag_d = 1'b0;
    bv = '0; mn = '0; mx = '0; bc = '0; ad = '0;
    xj = coord_rd_q[XW-1:0];
    yj = coord_rd_q[2*XW-1:XW];
    pc = point_count_q;
    px = '0; py = '0;

    case (state_q)
      toi_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == toi_pkg::MODE_LOAD) begin
            if ((IDX_W+1)'(in_idx) < (IDX_W+1)'(MAX_POINTS)) begin
              coord_we = 1'b1;
              tour_we  = 1'b1;
            end
          end else begin
            if (pc < toi_pkg::PCNT_W'(2)) n_d = CW'(2);
            else if (pc > MAXP) n_d = CW'(MAX_POINTS);
            else n_d = CW'(pc);
            if (rng_seed_q != '0) rng_d = rng_seed_q;
            i_d     = '0;
            tcnt_d  = '0;
            state_d = toi_pkg::ST_B_RDI;
          end
        end
      end
      // table build: one pair (i, j) at a time
      toi_pkg::ST_B_RDI: begin
        coord_re = 1'b1; coord_raddr = i_q[IW-1:0];
        j_d = i_q + 1'b1;
        state_d = toi_pkg::ST_B_GETI;
      end
      toi_pkg::ST_B_GETI: begin
        xi_d = xj; yi_d = yj;
        state_d = toi_pkg::ST_B_RDJ;
      end
      toi_pkg::ST_B_RDJ: begin
        coord_re = 1'b1; coord_raddr = j_q[IW-1:0];
        state_d = toi_pkg::ST_B_DIFF;
      end
      toi_pkg::ST_B_DIFF: begin
        dx_d = (xi_q > xj) ? xi_q - xj : xj - xi_q;
        dy_d = (yi_q > yj) ? yi_q - yj : yj - yi_q;
        state_d = toi_pkg::ST_B_SQX;
      end
      toi_pkg::ST_B_SQX: begin
        mul_in  = dx_q;
        state_d = toi_pkg::ST_B_SQY;
      end
      toi_pkg::ST_B_SQY: begin
        mul_in  = dy_q;
        acc_d   = mul_q;
        state_d = toi_pkg::ST_B_SQS;
      end
      toi_pkg::ST_B_SQS: begin
        rad_d  = RW'(SW'(acc_q) + SW'(mul_q)) << (2 * DIST_FRAC_BITS);
        sqr_d  = '0;
        root_d = '0;
        k_d    = '0;
        state_d = toi_pkg::ST_B_ROOT;
      end
      toi_pkg::ST_B_ROOT: begin
        rad_d = rad_q << 2;
        if (sq_rm >= sq_trial) begin
          sqr_d  = sq_rm - sq_trial;
          root_d = {root_q[K-2:0], 1'b1};
        end else begin
          sqr_d  = sq_rm;
          root_d = {root_q[K-2:0], 1'b0};
        end
        k_d = k_q + 1'b1;
        if (k_q == KCW'(K - 1)) state_d = toi_pkg::ST_B_WR;
      end
      toi_pkg::ST_B_WR: begin
        dist_we = 1'b1;
        j_d = j_q + 1'b1;
        if (j_q + 1'b1 == n_q) begin
          i_d = i_q + 1'b1;
          if (i_q + 2'd2 == n_q) state_d = toi_pkg::ST_T_CHK;
          else state_d = toi_pkg::ST_B_RDI;
        end else begin
          state_d = toi_pkg::ST_B_RDJ;
        end
      end
      // trials
      toi_pkg::ST_T_CHK: begin
        if (tcnt_q == trial_count_q) begin
          i_d = '0;
          state_d = toi_pkg::ST_E_RD;
        end else begin
          tcnt_d    = tcnt_q + 1'b1;
          rng_d     = toi_pkg::xorshift(rng_q);
          mod_val_d = toi_pkg::xorshift(rng_q);
          mod_rem_d = '0;
          mod_cnt_d = '0;
          state_d   = toi_pkg::ST_T_MODA;
        end
      end
      toi_pkg::ST_T_MODA, toi_pkg::ST_T_MODB: begin
        mod_rem_d = mod_step;
        mod_val_d = mod_val_q << 1;
        mod_cnt_d = mod_cnt_q + 1'b1;
        if (mod_cnt_q == 5'd31) begin
          state_d = (state_q == toi_pkg::ST_T_MODA) ? toi_pkg::ST_T_RNGB
                                                     : toi_pkg::ST_T_ORD;
        end
      end
      toi_pkg::ST_T_RNGB: begin
        a_d       = IW'(mod_rem_q);
        rng_d     = toi_pkg::xorshift(rng_q);
        mod_val_d = toi_pkg::xorshift(rng_q);
        mod_rem_d = '0;
        mod_cnt_d = '0;
        state_d   = toi_pkg::ST_T_MODB;
      end
      toi_pkg::ST_T_ORD: begin
        bv = CW'(mod_rem_q);
        if (CW'(a_q) == bv) begin
          state_d = toi_pkg::ST_T_CHK;
        end else begin
          mn = (CW'(a_q) < bv) ? CW'(a_q) : bv;
          mx = (CW'(a_q) < bv) ? bv : CW'(a_q);
          a_d = IW'(mn);
          b_d = IW'(mx);
          c_d = IW'(mn + 1'b1);
          d_d = (mx + 1'b1 == n_q) ? '0 : IW'(mx + 1'b1);
          state_d = toi_pkg::ST_T_RTA;
        end
      end
      toi_pkg::ST_T_RTA: begin
        tour_re = 1'b1; tour_raddr = a_q;
        state_d = toi_pkg::ST_T_RTB;
      end
      toi_pkg::ST_T_RTB: begin
        tour_re = 1'b1; tour_raddr = b_q;
        ca_d = sat_city(tour_rd_q, n_q);
        state_d = toi_pkg::ST_T_RTC;
      end
      toi_pkg::ST_T_RTC: begin
        tour_re = 1'b1; tour_raddr = c_q;
        cb_d = sat_city(tour_rd_q, n_q);
        state_d = toi_pkg::ST_T_RTD;
      end
      toi_pkg::ST_T_RTD: begin
        tour_re = 1'b1; tour_raddr = d_q;
        cc_d = sat_city(tour_rd_q, n_q);
        state_d = toi_pkg::ST_T_D1;
      end
      // edge lengths: new pair (a,b)+(c,d), old pair (a,c)+(b,d)
      toi_pkg::ST_T_D1: begin
        cd_d = sat_city(tour_rd_q, n_q);
        px = ca_q; py = cb_q; dist_re = 1'b1;
        state_d = toi_pkg::ST_T_D2;
      end
      toi_pkg::ST_T_D2: begin
        px = cc_q; py = cd_q; dist_re = 1'b1;
        new_d = (DW+1)'(dv);
        state_d = toi_pkg::ST_T_D3;
      end
      toi_pkg::ST_T_D3: begin
        px = ca_q; py = cc_q; dist_re = 1'b1;
        new_d = new_q + (DW+1)'(dv);
        state_d = toi_pkg::ST_T_D4;
      end
      toi_pkg::ST_T_D4: begin
        px = cb_q; py = cd_q; dist_re = 1'b1;
        old_d = (DW+1)'(dv);
        state_d = toi_pkg::ST_T_ADD;
      end
      toi_pkg::ST_T_ADD: begin
        old_d = old_q + (DW+1)'(dv);
        state_d = toi_pkg::ST_T_CMP;
      end
      toi_pkg::ST_T_CMP: begin
        state_d = (new_q < old_q) ? toi_pkg::ST_T_REVS : toi_pkg::ST_T_CHK;
      end
      // pick the shorter cyclic segment
      toi_pkg::ST_T_REVS: begin
        bc = PW'(b_q) - PW'(c_q);
        ad = PW'(a_q) + PW'(n_q) - PW'(d_q);
        if (bc > ad) begin
          lo_d = PW'(d_q);
          hi_d = PW'(a_q) + PW'(n_q);
        end else begin
          lo_d = PW'(c_q);
          hi_d = PW'(b_q);
        end
        state_d = toi_pkg::ST_SW0;
      end
      toi_pkg::ST_SW0: begin
        if (lo_q < hi_q) begin
          tour_re = 1'b1; tour_raddr = wrap_pos(lo_q, n_q);
          state_d = toi_pkg::ST_SW1;
        end else begin
          state_d = toi_pkg::ST_T_CHK;
        end
      end
      toi_pkg::ST_SW1: begin
        tp_d = tour_rd_q;
        tour_re = 1'b1; tour_raddr = wrap_pos(hi_q, n_q);
        state_d = toi_pkg::ST_SW2;
      end
      toi_pkg::ST_SW2: begin
        tour_we = 1'b1; tour_waddr = wrap_pos(lo_q, n_q); tour_wdata = tour_rd_q;
        state_d = toi_pkg::ST_SW3;
      end
      toi_pkg::ST_SW3: begin
        tour_we = 1'b1; tour_waddr = wrap_pos(hi_q, n_q); tour_wdata = tp_q;
        lo_d = lo_q + 1'b1;
        hi_d = hi_q - 1'b1;
        state_d = toi_pkg::ST_SW0;
      end
      // emit the tour
      toi_pkg::ST_E_RD: begin
        tour_re = 1'b1; tour_raddr = i_q[IW-1:0];
        state_d = toi_pkg::ST_E_LD;
      end
      toi_pkg::ST_E_LD: begin
        out_valid_d = 1'b1;
        out_pos_d   = IDX_W'(i_q);
        out_city_d  = tour_rd_q;
        out_last_d  = (i_q + 1'b1 == n_q);
        state_d     = toi_pkg::ST_E_OUT;
      end
      toi_pkg::ST_E_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          i_d = i_q + 1'b1;
          state_d = out_last_q ? toi_pkg::ST_IDLE : toi_pkg::ST_E_RD;
        end
      end
      default: state_d = toi_pkg::ST_IDLE;
    endcase

    // upper-triangle address of the city pair
    diag_d     = (px == py);
    dist_raddr = (px < py) ? {px, py} : {py, px};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= toi_pkg::ST_IDLE;
      rng_q       <= toi_pkg::RNG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rng_q       <= rng_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_pos_q <= out_pos_d; out_city_q <= out_city_d; out_last_q <= out_last_d;
    n_q <= n_d; i_q <= i_d; j_q <= j_d;
    xi_q <= xi_d; yi_q <= yi_d; dx_q <= dx_d; dy_q <= dy_d;
    mul_q <= mul_in * mul_in;
    acc_q <= acc_d; rad_q <= rad_d; sqr_q <= sqr_d; root_q <= root_d; k_q <= k_d;
    tcnt_q <= tcnt_d; mod_val_q <= mod_val_d; mod_rem_q <= mod_rem_d;
    mod_cnt_q <= mod_cnt_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    ca_q <= ca_d; cb_q <= cb_d; cc_q <= cc_d; cd_q <= cd_d;
    new_q <= new_d; old_q <= old_d; lo_q <= lo_d; hi_q <= hi_d; tp_q <= tp_d;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (coord_we) coord_mem[coord_waddr] <= coord_wdata;
    if (coord_re) coord_rd_q <= coord_mem[coord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tour_we) tour_mem[tour_waddr] <= tour_wdata;
    if (tour_re) tour_rd_q <= tour_mem[tour_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= root_q;
    if (dist_re) begin
      dist_rd_q <= dist_mem[dist_raddr];
      diag_q    <= diag_d;
    end
  end

  // checks
  `TOI_ASSERT_NEVER(a_ready_while_out, clk_i, rst_ni, s_axis_tready && m_axis_tvalid)
  `TOI_ASSERT(a_pos_in_range, clk_i, rst_ni, !m_axis_tvalid || (CW'(out_pos_q) < n_q))
  `TOI_ASSERT(a_last_ends_run, clk_i, rst_ni,
              (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
              (state_q == toi_pkg::ST_IDLE))
  `TOI_ASSERT(a_trial_ordered, clk_i, rst_ni,
              (state_q == toi_pkg::ST_T_REVS) |-> (a_q < b_q))

endmodule

>>> tb/two_opt_tour_improver_tb.sv
// ----------------------------------------------------------------------------
// two_opt_tour_improver_tb
// Streams point loads and run words into the 2-opt tour improver and checks
// every emitted tour word against a local 2-opt search of the same tour.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_opt_tour_improver_tb;

  typedef struct {
    logic                      mode;
    logic [toi_pkg::IDX_W-1:0] idx;
    logic [toi_pkg::CRD_W-1:0] x;
    logic [toi_pkg::CRD_W-1:0] y;
    logic [toi_pkg::IDX_W-1:0] city;
  } item_t;

  typedef struct {
    logic [toi_pkg::IDX_W-1:0] pos;
    logic [toi_pkg::IDX_W-1:0] city;
    logic                      last;
  } tour_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [toi_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_opt_tour_improver dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // mirror of the block's registers and memories
  logic [toi_pkg::PCNT_W-1:0] cfg_points = 7'd64;
  logic [toi_pkg::TCNT_W-1:0] cfg_trials = '0;
  logic [toi_pkg::RNG_W-1:0]  cfg_seed = '0;
  logic [toi_pkg::CRD_W-1:0]  pt_x [64];
  logic [toi_pkg::CRD_W-1:0]  pt_y [64];
  logic [toi_pkg::IDX_W-1:0]  tour [64];
  logic [24:0]                dist_tbl [64][64];
  logic [toi_pkg::RNG_W-1:0]  rng = toi_pkg::RNG_RESET;

  item_t      pending_words[$];
  tour_word_t expected_tour[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         large_runs = 0;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #200000000;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [24:0] root_q8(input logic [63:0] s);
    logic [63:0] rad, root, rem, trial;
    rad = s << (2 * toi_pkg::DIST_FRAC_BITS_DEF);
    root = 0;
    rem = 0;
    for (int k = toi_pkg::COORD_BITS_DEF + toi_pkg::DIST_FRAC_BITS_DEF; k >= 0; k--) begin
      rem = (rem << 2) | ((rad >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[24:0];
  endfunction

  function automatic logic [toi_pkg::RNG_W-1:0] rng_next();
    logic [toi_pkg::RNG_W-1:0] v;
    v = rng;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    rng = v;
    return v;
  endfunction

  function automatic logic [25:0] edge_len(input int pa, input int pb, input int n);
    int ca, cb;
    ca = (tour[pa] >= n) ? n - 1 : tour[pa];
    cb = (tour[pb] >= n) ? n - 1 : tour[pb];
    return {1'b0, dist_tbl[ca][cb]};
  endfunction

  task automatic improve_tour();
    int n, a, b, c, d, lo, hi, p, q, s;
    logic [63:0] dx, dy;
    logic [toi_pkg::IDX_W-1:0] t;
    n = cfg_points;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    if (cfg_seed != 0) rng = cfg_seed;
    for (int i = 0; i < n; i++) begin
      dist_tbl[i][i] = '0;
      for (int j = i + 1; j < n; j++) begin
        dx = (pt_x[i] > pt_x[j]) ? pt_x[i] - pt_x[j] : pt_x[j] - pt_x[i];
        dy = (pt_y[i] > pt_y[j]) ? pt_y[i] - pt_y[j] : pt_y[j] - pt_y[i];
        dist_tbl[i][j] = root_q8(dx * dx + dy * dy);
        dist_tbl[j][i] = dist_tbl[i][j];
      end
    end
    for (int tr = 0; tr < cfg_trials; tr++) begin
      a = rng_next() % n;
      b = rng_next() % n;
      if (a == b) continue;
      if (a > b) begin
        s = a; a = b; b = s;
      end
      c = (a + 1) % n;
      d = (b + 1) % n;
      if (edge_len(a, b, n) + edge_len(c, d, n) <
          edge_len(a, c, n) + edge_len(b, d, n)) begin
        lo = c;
        hi = b;
        if (b - c > a + n - d) begin
          lo = d;
          hi = a + n;
        end
        while (lo < hi) begin
          p = (lo < n) ? lo : lo - n;
          q = (hi < n) ? hi : hi - n;
          t = tour[p];
          tour[p] = tour[q];
          tour[q] = t;
          lo++;
          hi--;
        end
      end
    end
    for (int i = 0; i < n; i++)
      expected_tour.push_back('{pos: i[toi_pkg::IDX_W-1:0], city: tour[i],
                                last: (i == n - 1)});
  endtask

  // ----------------------------------------------------- input acceptance
  logic taken = 1'b0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      taken = 1'b1;
      if (s_axis_tuser == toi_pkg::MODE_LOAD) begin
        pt_x[s_axis_tdata[5:0]] = s_axis_tdata[21:6];
        pt_y[s_axis_tdata[5:0]] = s_axis_tdata[37:22];
        tour[s_axis_tdata[5:0]] = s_axis_tdata[43:38];
      end else begin
        improve_tour();
      end
    end
  end

  // ------------------------------------------------------------ driver
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    item_t w;
    if (!s_axis_tvalid || taken) begin
      taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        s_axis_tdata <= {4'b0, w.city, w.y, w.x, w.idx};
        s_axis_tuser <= w.mode;
        s_axis_tvalid <= 1'b1;
        items_sent++;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: long ready stretches alternate with choppy ones
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase = (stall_phase + 1) % 300;
    if (stall_phase < 120) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) < 4);
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk_i) begin
    tour_word_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_tour.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tour word %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        e = expected_tour.pop_front();
        if (m_axis_tdata[5:0] !== e.pos || m_axis_tdata[11:6] !== e.city ||
            m_axis_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tour word mismatch: exp pos %0d city %0d last %b, got %0d %0d %b",
                     e.pos, e.city, e.last, m_axis_tdata[5:0], m_axis_tdata[11:6],
                     m_axis_tlast);
        end
      end
    end
  end

  // ------------------------------------------------------------ helpers
  task automatic reg_write(input logic [toi_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == {toi_pkg::REG_POINT_COUNT, 2'b00})
      cfg_points = val[toi_pkg::PCNT_W-1:0];
    else if (addr == {toi_pkg::REG_TRIAL_COUNT, 2'b00})
      cfg_trials = val[toi_pkg::TCNT_W-1:0];
    else if (addr == {toi_pkg::REG_RNG_SEED, 2'b00})
      cfg_seed = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int pc, input int tc, input logic [31:0] seed);
    reg_write({toi_pkg::REG_POINT_COUNT, 2'b00}, 32'(pc));
    reg_write({toi_pkg::REG_TRIAL_COUNT, 2'b00}, 32'(tc));
    reg_write({toi_pkg::REG_RNG_SEED, 2'b00}, seed);
  endtask

  task automatic push_load(input int idx, input int x, input int y, input int city);
    pending_words.push_back('{mode: toi_pkg::MODE_LOAD, idx: toi_pkg::IDX_W'(idx),
                              x: toi_pkg::CRD_W'(x), y: toi_pkg::CRD_W'(y),
                              city: toi_pkg::IDX_W'(city)});
  endtask

  task automatic push_run();
    pending_words.push_back('{mode: toi_pkg::MODE_RUN, idx: toi_pkg::IDX_W'($urandom),
                              x: toi_pkg::CRD_W'($urandom), y: toi_pkg::CRD_W'($urandom),
                              city: toi_pkg::IDX_W'($urandom)});
  endtask

  // wait for the block to drain, then let it return to idle
  task automatic drain();
    wait (pending_words.size() == 0 && !s_axis_tvalid && expected_tour.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------ stimulus
  initial begin
    int n, loads;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // fill every slot; corners of the coordinate range first
    push_load(0, 0, 0, 63);
    push_load(1, 16'hFFFF, 16'hFFFF, 0);
    push_load(2, 16'hFFFF, 0, 2);
    push_load(3, 0, 16'hFFFF, 3);
    for (int i = 4; i < 64; i++) push_load(i, $urandom, $urandom, $urandom_range(0, 63));
    // reset settings: full tour, no trials
    push_run();
    drain();

    // count below range, all-ones seed
    set_config(0, 5, 32'hFFFF_FFFF);
    push_run();
    drain();
    set_config(1, 8, 0);
    push_run();
    drain();
    // largest trial count is written, then replaced before any run
    reg_write({toi_pkg::REG_TRIAL_COUNT, 2'b00}, 32'h00FF_FFFF);
    reg_write(4'd12, 32'd3);
    set_config(2, 20, 32'h1234_5678);
    push_run();
    push_load(0, 100, 200, 1);
    push_load(1, 300, 50, 0);
    push_run();
    drain();
    // count above range saturates to the full tour
    set_config(127, 40, 0);
    push_run();
    large_runs++;
    drain();

    // random phases
    while (items_sent < 460) begin
      if ($urandom_range(0, 9) == 0 && large_runs < 3) begin
        n = $urandom_range(40, 64);
        large_runs++;
      end else begin
        n = $urandom_range(2, 12);
      end
      set_config(n, $urandom_range(0, 60),
                 ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
      for (int r = 0; r < $urandom_range(1, 2); r++) begin
        loads = $urandom_range(0, 18);
        for (int i = 0; i < loads; i++)
          push_load(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, n - 1),
                    $urandom, $urandom, $urandom_range(0, 63));
        push_run();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_tour.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
